// ===== sv/s256bh_pkg.sv =====
// Package for the SHA-256 byte stream hasher.
// Holds the round constants, initial hash values and a rotate helper function.
// No dependencies.
package s256bh_pkg;

	localparam int unsigned WordW = 32;

	typedef logic [WordW-1:0] word_t;

	typedef enum logic [5:0] {
		ST_LOAD = 6'b000001,
		ST_PAD  = 6'b000010,
		ST_INIT = 6'b000100,
		ST_RND  = 6'b001000,
		ST_ADD  = 6'b010000,
		ST_OUT  = 6'b100000
	} state_t;

	localparam word_t InitH [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam word_t RoundK [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	function automatic word_t ror(input word_t x, input int unsigned n);
		return (x >> n) | (x << (WordW - n));
	endfunction

endpackage

// ===== sv/sha256_byte_stream_hasher.sv =====
// Top level of the SHA-256 byte stream hasher: byte buffer, shared round unit and
// output sequencer in one module. Depends on s256bh_pkg.
//
// channel | dir | tdata                                | tuser | tlast
// s_axis  | in  | data_byte[7:0]                       | -     | end_of_message
// m_axis  | out | digest_word[31:0], word_index[34:32] | -     | final_word
//
// Bytes are accepted only in the load state. The 64th byte of a block starts a setup step,
// the rounds of the shared round unit and a chaining add.
// The last byte adds a padding step per empty buffer slot, a padding pass over a fresh block and
// a second compression when the length does not fit, and eight output items that wait
// on m_axis_tready. Reset puts the initial hash values in place; no clearing pass is needed.
module sha256_byte_stream_hasher (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // data_byte[7:0]
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,  // digest_word[31:0], word_index[34:32], zeros
	output logic        m_axis_tlast
);
	import s256bh_pkg::*;

	state_t      state_q;
	logic [5:0]  fill_q;
	logic [63:0] bitlen_q;
	word_t       h_q [8];
	word_t       r_q [8];
	word_t       w_q [16];
	logic [5:0]  rnd_q;
	logic        last_q;
	logic        mark_q;
	logic        len_done_q;
	logic [2:0]  oidx_q;

	logic        acc;
	word_t       wnew, wcur, s0, s1, t1, t2, x, y;
	logic [7:0]  padb;

	assign acc = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = (state_q == ST_LOAD);
	assign m_axis_tvalid = (state_q == ST_OUT);
	assign m_axis_tdata  = {5'd0, oidx_q, h_q[oidx_q]};
	assign m_axis_tlast  = (oidx_q == 3'd7);

	always_comb begin
		x = w_q[1];
		y = w_q[14];
		wnew = w_q[0] + (ror(x, 7) ^ ror(x, 18) ^ (x >> 3)) +
			(ror(y, 17) ^ ror(y, 19) ^ (y >> 10)) + w_q[9];
		wcur = w_q[0];
		s1 = ror(r_q[4], 6) ^ ror(r_q[4], 11) ^ ror(r_q[4], 25);
		t1 = r_q[7] + s1 + ((r_q[4] & r_q[5]) ^ (~r_q[4] & r_q[6])) + RoundK[rnd_q] + wcur;
		s0 = ror(r_q[0], 2) ^ ror(r_q[0], 13) ^ ror(r_q[0], 22);
		t2 = s0 + ((r_q[0] & r_q[1]) ^ (r_q[0] & r_q[2]) ^ (r_q[1] & r_q[2]));
		if (mark_q) begin
			padb = 8'h80;
		end else if (len_done_q && fill_q >= 6'd56) begin
			padb = bitlen_q[{~fill_q[2:0], 3'b000} +: 8];
		end else begin
			padb = 8'h00;
		end
	end

	// Bytes land big-endian in the schedule window, which then rolls during the rounds.
	always_ff @(posedge clk) begin
		if (acc) begin
			w_q[fill_q[5:2]][{~fill_q[1:0], 3'b000} +: 8] <= s_axis_tdata;
		end else if (state_q == ST_PAD) begin
			w_q[fill_q[5:2]][{~fill_q[1:0], 3'b000} +: 8] <= padb;
		end else if (state_q == ST_RND) begin
			for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
			w_q[15] <= wnew;
		end
		if (state_q == ST_INIT) begin
			for (int i = 0; i < 8; i++) r_q[i] <= h_q[i];
		end else if (state_q == ST_RND) begin
			r_q[7] <= r_q[6]; r_q[6] <= r_q[5]; r_q[5] <= r_q[4];
			r_q[4] <= r_q[3] + t1;
			r_q[3] <= r_q[2]; r_q[2] <= r_q[1]; r_q[1] <= r_q[0];
			r_q[0] <= t1 + t2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_LOAD;
			fill_q     <= '0;
			bitlen_q   <= '0;
			rnd_q      <= '0;
			last_q     <= 1'b0;
			mark_q     <= 1'b0;
			len_done_q <= 1'b0;
			oidx_q     <= '0;
			for (int i = 0; i < 8; i++) h_q[i] <= InitH[i];
		end else begin
			unique case (state_q)
				ST_LOAD: begin
					if (acc) begin
						fill_q   <= fill_q + 6'd1;
						bitlen_q <= bitlen_q + 64'd8;
						if (s_axis_tlast) begin
							last_q <= 1'b1;
							mark_q <= 1'b1;
						end
						if (fill_q == 6'd63) begin
							state_q <= ST_INIT;
						end else if (s_axis_tlast) begin
							state_q <= ST_PAD;
						end
					end
				end
				ST_PAD: begin
					fill_q <= fill_q + 6'd1;
					if (mark_q) begin
						// The length fits only if 0x80 lands before the last eight bytes.
						mark_q     <= 1'b0;
						len_done_q <= (fill_q < 6'd56);
					end
					if (fill_q == 6'd63) state_q <= ST_INIT;
				end
				ST_INIT: begin
					rnd_q   <= '0;
					state_q <= ST_RND;
				end
				ST_RND: begin
					rnd_q <= rnd_q + 6'd1;
					if (rnd_q == 6'd63) state_q <= ST_ADD;
				end
				ST_ADD: begin
					for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + r_q[i];
					fill_q <= '0;
					if (len_done_q) begin
						state_q <= ST_OUT;
						oidx_q  <= '0;
					end else if (last_q) begin
						// Padding goes on in a fresh block that carries the length.
						len_done_q <= 1'b1;
						state_q    <= ST_PAD;
					end else begin
						state_q <= ST_LOAD;
					end
				end
				ST_OUT: begin
					if (m_axis_tready) begin
						oidx_q <= oidx_q + 3'd1;
						if (oidx_q == 3'd7) begin
							state_q    <= ST_LOAD;
							bitlen_q   <= '0;
							last_q     <= 1'b0;
							len_done_q <= 1'b0;
							for (int i = 0; i < 8; i++) h_q[i] <= InitH[i];
						end
					end
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_no_in_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !s_axis_tready) else $error("input taken while output");
	a_out_order: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=> m_axis_tvalid)
		else $error("digest burst broken");
	a_rnd_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_INIT) |=> (state_q == ST_RND && rnd_q == 6'd0))
		else $error("round start");
`endif
endmodule

// ===== bench/sha256_byte_stream_hasher_tb.sv =====
// Testbench for the SHA-256 byte stream hasher: streams messages byte by byte and
// checks each digest word against a SHA-256 predictor kept in the bench.
// Depends on s256bh_pkg and sha256_byte_stream_hasher.
`timescale 1ns / 100ps

module sha256_byte_stream_hasher_tb;
	import s256bh_pkg::*;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_message;
	} byte_item_t;

	typedef struct packed {
		word_t      digest_word;
		logic [2:0] word_index;
		logic       final_word;
	} digest_item_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = '0;
	logic        s_axis_tlast = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [39:0] m_axis_tdata;
	logic        m_axis_tlast;

	byte_item_t   pending_bytes[$];
	digest_item_t expected_digests[$];
	word_t        hash_state[8];
	logic [7:0]   msg_block[64];
	int unsigned  block_fill;
	logic [63:0]  msg_bits;
	int unsigned  errors = 0;
	int unsigned  idle_cycles = 0;
	int unsigned  send_gap = 0;
	int unsigned  recv_gap = 0;
	bit           in_taken = 1'b0;
	bit           hold_off_done = 1'b0;
	bit           hold_off_armed = 1'b0;
	int unsigned  hold_count = 0;

	sha256_byte_stream_hasher i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	always #5 clk = ~clk;

	function automatic word_t rot_right(word_t x, int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	function automatic int unsigned random_gap();
		if ($urandom_range(0, 19) == 0) begin
			return $urandom_range(20, 150);
		end
		return ($urandom_range(0, 2) == 0) ? $urandom_range(0, 3) : 0;
	endfunction

	task automatic compress_msg_block();
		word_t w[64];
		word_t v[8];
		word_t t1, t2;
		for (int i = 0; i < 16; i++) begin
			w[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
		end
		for (int i = 16; i < 64; i++) begin
			w[i] = w[i-16] + w[i-7]
				+ (rot_right(w[i-15], 7) ^ rot_right(w[i-15], 18) ^ (w[i-15] >> 3))
				+ (rot_right(w[i-2], 17) ^ rot_right(w[i-2], 19) ^ (w[i-2] >> 10));
		end
		for (int i = 0; i < 8; i++) begin
			v[i] = hash_state[i];
		end
		for (int t = 0; t < 64; t++) begin
			t1 = v[7] + (rot_right(v[4], 6) ^ rot_right(v[4], 11) ^ rot_right(v[4], 25))
				+ ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundK[t] + w[t];
			t2 = (rot_right(v[0], 2) ^ rot_right(v[0], 13) ^ rot_right(v[0], 22))
				+ ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
			v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
			v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
		end
		for (int i = 0; i < 8; i++) begin
			hash_state[i] += v[i];
		end
	endtask

	task automatic restart_digest();
		for (int i = 0; i < 8; i++) begin
			hash_state[i] = InitH[i];
		end
		block_fill = 0;
		msg_bits = '0;
	endtask

	task automatic absorb_byte(byte_item_t it);
		digest_item_t d;
		int unsigned n;
		msg_block[block_fill] = it.data_byte;
		block_fill++;
		msg_bits += 64'd8;
		if (block_fill == 64) begin
			compress_msg_block();
			block_fill = 0;
		end
		if (!it.end_of_message) begin
			return;
		end
		n = block_fill;
		msg_block[n] = 8'h80;
		n++;
		if (n > 56) begin
			while (n < 64) begin
				msg_block[n] = 8'h00;
				n++;
			end
			compress_msg_block();
			n = 0;
		end
		while (n < 56) begin
			msg_block[n] = 8'h00;
			n++;
		end
		for (int i = 0; i < 8; i++) begin
			msg_block[56+i] = msg_bits[63-8*i -: 8];
		end
		compress_msg_block();
		for (int i = 0; i < 8; i++) begin
			d.digest_word = hash_state[i];
			d.word_index = 3'(i);
			d.final_word = (i == 7);
			expected_digests.push_back(d);
		end
		restart_digest();
	endtask

	task automatic queue_message(int unsigned len, int unsigned fill_mode);
		byte_item_t it;
		for (int unsigned i = 0; i < len; i++) begin
			case (fill_mode)
				0: it.data_byte = 8'h00;
				1: it.data_byte = 8'hff;
				default: it.data_byte = 8'($urandom_range(0, 255));
			endcase
			it.end_of_message = (i == len - 1);
			pending_bytes.push_back(it);
		end
	endtask

	always @(negedge clk) begin
		if (arst_n) begin
			if (!s_axis_tvalid || in_taken) begin
				if (send_gap > 0) begin
					send_gap <= send_gap - 1;
					s_axis_tvalid <= 1'b0;
				end else if (pending_bytes.size() > 0) begin
					{s_axis_tdata, s_axis_tlast} <= pending_bytes.pop_front();
					s_axis_tvalid <= 1'b1;
					send_gap <= random_gap();
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// The long hold-off starts right after reset, while the first messages are in flight.
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_off_armed && !hold_off_done) begin
				m_axis_tready <= 1'b0;
				hold_count <= hold_count + 1;
				if (hold_count == 600) begin
					hold_off_done <= 1'b1;
				end
			end else if (recv_gap > 0) begin
				recv_gap <= recv_gap - 1;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
				recv_gap <= random_gap();
			end
		end
	end

	always @(posedge clk) begin
		digest_item_t got, want;
		if (arst_n) begin
			in_taken <= s_axis_tvalid && s_axis_tready;
			if (s_axis_tvalid && s_axis_tready) begin
				absorb_byte({s_axis_tdata, s_axis_tlast});
			end
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
				idle_cycles <= 0;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
			if (idle_cycles > 20000) begin
				$display("sha256_byte_stream_hasher verification failed");
				$finish;
			end
			if (m_axis_tvalid && m_axis_tready) begin
				got.digest_word = m_axis_tdata[31:0];
				got.word_index = m_axis_tdata[34:32];
				got.final_word = m_axis_tlast;
				if (expected_digests.size() == 0) begin
					errors++;
					$display("%0t: unexpected digest word %h", $time, got);
				end else begin
					want = expected_digests.pop_front();
					if (got.digest_word !== want.digest_word) begin
						errors++;
						$display("%0t: digest_word expected %h actual %h", $time,
							want.digest_word, got.digest_word);
					end
					if (got.word_index !== want.word_index) begin
						errors++;
						$display("%0t: word_index expected %0d actual %0d", $time,
							want.word_index, got.word_index);
					end
					if (got.final_word !== want.final_word) begin
						errors++;
						$display("%0t: final_word expected %b actual %b", $time,
							want.final_word, got.final_word);
					end
				end
			end
		end
	end

	initial begin
		int unsigned total;
		restart_digest();
		// Directed: a single zero byte, a length that pushes the length field into a
		// second block, and a final byte that fills the block.
		queue_message(1, 0);
		queue_message(56, 1);
		queue_message(64, 2);
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		total = 121;
		while (total < 130) begin
			int unsigned len;
			len = $urandom_range(1, 6);
			queue_message(len, $urandom_range(0, 5) == 0 ? $urandom_range(0, 1) : 2);
			total += len;
		end
		hold_off_armed = 1'b1;
		wait (pending_bytes.size() == 0 && !s_axis_tvalid && hold_off_done);
		fork
			wait (expected_digests.size() == 0);
			begin
				repeat (100000) @(posedge clk);
			end
		join_any
		disable fork;
		repeat (200) @(posedge clk);
		if (errors == 0 && expected_digests.size() == 0) begin
			$display("sha256_byte_stream_hasher verification clean");
		end else begin
			$display("sha256_byte_stream_hasher verification failed");
		end
		$finish;
	end

endmodule

// ===== files.f =====
sv/s256bh_pkg.sv
sv/sha256_byte_stream_hasher.sv
bench/sha256_byte_stream_hasher_tb.sv
